// ===== hdl/jtw_pkg.sv =====
// ----------------------------------------------------------------------------
// jtw_pkg - shared definitions for the JTAG TAP state walker
// TAP state codes, TAP transition function, microword format and the
// microprogram ROM that routes the TAP from its tracked state to a target.
// ----------------------------------------------------------------------------
package jtw_pkg;

    typedef logic [3:0] t_tap;

    // TAP state codes; a command's opcode uses the same encoding
    localparam t_tap ST_TLR      = 4'd0;
    localparam t_tap ST_RTI      = 4'd1;
    localparam t_tap ST_SEL_DR   = 4'd2;
    localparam t_tap ST_CAP_DR   = 4'd3;
    localparam t_tap ST_SHIFT_DR = 4'd4;
    localparam t_tap ST_EXIT1_DR = 4'd5;
    localparam t_tap ST_PAUSE_DR = 4'd6;
    localparam t_tap ST_EXIT2_DR = 4'd7;
    localparam t_tap ST_UPD_DR   = 4'd8;
    localparam t_tap ST_SEL_IR   = 4'd9;
    localparam t_tap ST_CAP_IR   = 4'd10;
    localparam t_tap ST_SHIFT_IR = 4'd11;
    localparam t_tap ST_EXIT1_IR = 4'd12;
    localparam t_tap ST_PAUSE_IR = 4'd13;
    localparam t_tap ST_EXIT2_IR = 4'd14;
    localparam t_tap ST_UPD_IR   = 4'd15;

    // position of a state within its scan column, counted from Select
    localparam t_tap COL_CAP   = 4'd1;
    localparam t_tap COL_SHIFT = 4'd2;
    localparam t_tap COL_EXIT1 = 4'd3;
    localparam t_tap COL_PAUSE = 4'd4;
    localparam t_tap COL_EXIT2 = 4'd5;
    localparam t_tap COL_UPD   = 4'd6;

    localparam int STACK_DEPTH = 8;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    localparam int UADDR_W = 7;
    typedef logic [UADDR_W-1:0] t_uaddr;
    typedef logic [4:0]         t_uoff;

    typedef enum logic [2:0] {
        UOP_BR,     // jump to dest when mask bit of tracked state is set
        UOP_CALL,   // push return frame, jump to dest, load frame bit
        UOP_EMIT,   // emit one pulse, advance
        UOP_EMRET,  // emit one pulse, return
        UOP_RET     // return without a pulse
    } t_uop;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ONE,
        SRC_FRAME
    } t_src;

    typedef struct packed {
        t_uop        op;
        logic [15:0] mask;
        t_uaddr      dest;
        logic        tms;
        t_src        src;   // TDI of an emit, or frame bit of a call
        logic        smp;
    } t_uword;

    typedef struct packed {
        t_uaddr ret;
        logic   bit_val;
    } t_frame;

    // microprogram layout
    localparam t_uaddr A_RESET = 7'd0;
    localparam t_uaddr A_RTI   = 7'd5;
    localparam t_uaddr A_RET   = 7'd17;
    localparam t_uaddr A_DR    = 7'd18;
    localparam t_uaddr A_IR    = 7'd47;
    localparam t_uaddr COL_LEN = 7'd29;

    // routine offsets inside a column block
    localparam t_uoff O_SEL   = 5'd0;
    localparam t_uoff O_CAP   = 5'd4;
    localparam t_uoff O_SHIFT = 5'd8;
    localparam t_uoff O_EXIT1 = 5'd11;
    localparam t_uoff O_PAUSE = 5'd15;
    localparam t_uoff O_EXIT2 = 5'd18;
    localparam t_uoff O_UPD   = 5'd22;

    function automatic logic [15:0] f_onehot(input t_tap st);
        return 16'b1 << st;
    endfunction

    function automatic t_tap f_tap_next(input t_tap st, input logic tms);
        t_tap nx;
        unique case (st) inside
            ST_TLR:                  nx = tms ? ST_TLR      : ST_RTI;
            ST_RTI, ST_UPD_DR,
            ST_UPD_IR:               nx = tms ? ST_SEL_DR   : ST_RTI;
            ST_SEL_DR:               nx = tms ? ST_SEL_IR   : ST_CAP_DR;
            ST_CAP_DR, ST_SHIFT_DR:  nx = tms ? ST_EXIT1_DR : ST_SHIFT_DR;
            ST_EXIT1_DR:             nx = tms ? ST_UPD_DR   : ST_PAUSE_DR;
            ST_PAUSE_DR:             nx = tms ? ST_EXIT2_DR : ST_PAUSE_DR;
            ST_EXIT2_DR:             nx = tms ? ST_UPD_DR   : ST_SHIFT_DR;
            ST_SEL_IR:               nx = tms ? ST_TLR      : ST_CAP_IR;
            ST_CAP_IR, ST_SHIFT_IR:  nx = tms ? ST_EXIT1_IR : ST_SHIFT_IR;
            ST_EXIT1_IR:             nx = tms ? ST_UPD_IR   : ST_PAUSE_IR;
            ST_PAUSE_IR:             nx = tms ? ST_EXIT2_IR : ST_PAUSE_IR;
            ST_EXIT2_IR:             nx = tms ? ST_UPD_IR   : ST_SHIFT_IR;
            default:                 nx = ST_TLR;
        endcase
        return nx;
    endfunction

    function automatic t_uword f_word(input t_uop op, input logic [15:0] mask,
                                      input t_uaddr dest, input logic tms,
                                      input t_src src, input logic smp);
        t_uword w;
        w.op   = op;
        w.mask = mask;
        w.dest = dest;
        w.tms  = tms;
        w.src  = src;
        w.smp  = smp;
        return w;
    endfunction

    function automatic t_uaddr f_at(input t_uaddr cb, input t_uoff off);
        return cb + t_uaddr'(off);
    endfunction

    // One scan column: Select, Capture, Shift, Exit1, Pause, Exit2, Update.
    // Each routine but Shift and Pause returns at once when already there; else it calls
    // the routine of its usual predecessor when needed, then gives its own closing pulse.
    function automatic t_uword f_col_word(input t_uoff off, input logic is_ir);
        t_tap   b;
        t_uaddr cb;
        t_uword w;
        b  = is_ir ? ST_SEL_IR : ST_SEL_DR;
        cb = is_ir ? A_IR : A_DR;
        w  = f_word(UOP_RET, '0, A_RET, 1'b0, SRC_ZERO, 1'b0);
        case (off)
            // Select: DR goes through Run-Test/Idle, IR through Select-DR
            O_SEL:         w = f_word(UOP_BR, f_onehot(b), A_RET, 1'b0, SRC_ZERO, 1'b0);
            O_SEL + 5'd1:  w = f_word(UOP_BR, is_ir ? 16'b0 : f_onehot(ST_RTI),
                                      f_at(cb, O_SEL + 5'd3), 1'b0, SRC_ZERO, 1'b0);
            O_SEL + 5'd2:  w = f_word(UOP_CALL, '0, is_ir ? f_at(A_DR, O_SEL) : A_RTI,
                                      1'b0, SRC_ZERO, 1'b0);
            O_SEL + 5'd3:  w = f_word(UOP_EMRET, '0, A_RET, 1'b1, SRC_ZERO, 1'b0);
            // Capture
            O_CAP:         w = f_word(UOP_BR, f_onehot(b + COL_CAP), A_RET,
                                      1'b0, SRC_ZERO, 1'b0);
            O_CAP + 5'd1:  w = f_word(UOP_BR, f_onehot(b), f_at(cb, O_CAP + 5'd3),
                                      1'b0, SRC_ZERO, 1'b0);
            O_CAP + 5'd2:  w = f_word(UOP_CALL, '0, f_at(cb, O_SEL), 1'b0, SRC_ZERO, 1'b0);
            O_CAP + 5'd3:  w = f_word(UOP_EMRET, '0, A_RET, 1'b0, SRC_ZERO, 1'b0);
            // Shift: always one pulse into Shift, sampled
            O_SHIFT:       w = f_word(UOP_BR, f_onehot(b + COL_SHIFT) | f_onehot(b + COL_CAP)
                                      | f_onehot(b + COL_EXIT2),
                                      f_at(cb, O_SHIFT + 5'd2), 1'b0, SRC_ZERO, 1'b0);
            O_SHIFT + 5'd1: w = f_word(UOP_CALL, '0, f_at(cb, O_CAP), 1'b0, SRC_ZERO, 1'b0);
            O_SHIFT + 5'd2: w = f_word(UOP_EMRET, '0, A_RET, 1'b0, SRC_FRAME, 1'b1);
            // Exit1: TDI comes from the caller's frame bit
            O_EXIT1:       w = f_word(UOP_BR, f_onehot(b + COL_EXIT1), A_RET,
                                      1'b0, SRC_ZERO, 1'b0);
            O_EXIT1 + 5'd1: w = f_word(UOP_BR, f_onehot(b + COL_CAP) | f_onehot(b + COL_SHIFT),
                                       f_at(cb, O_EXIT1 + 5'd3), 1'b0, SRC_ZERO, 1'b0);
            O_EXIT1 + 5'd2: w = f_word(UOP_CALL, '0, f_at(cb, O_CAP), 1'b0, SRC_ZERO, 1'b0);
            O_EXIT1 + 5'd3: w = f_word(UOP_EMRET, '0, A_RET, 1'b1, SRC_FRAME, 1'b0);
            // Pause: always one pulse into Pause
            O_PAUSE:       w = f_word(UOP_BR, f_onehot(b + COL_EXIT1) | f_onehot(b + COL_PAUSE),
                                      f_at(cb, O_PAUSE + 5'd2), 1'b0, SRC_ZERO, 1'b0);
            O_PAUSE + 5'd1: w = f_word(UOP_CALL, '0, f_at(cb, O_EXIT1), 1'b0,
                                       is_ir ? SRC_ONE : SRC_ZERO, 1'b0);
            O_PAUSE + 5'd2: w = f_word(UOP_EMRET, '0, A_RET, 1'b0, SRC_ZERO, 1'b0);
            // Exit2
            O_EXIT2:       w = f_word(UOP_BR, f_onehot(b + COL_EXIT2), A_RET,
                                      1'b0, SRC_ZERO, 1'b0);
            O_EXIT2 + 5'd1: w = f_word(UOP_BR, f_onehot(b + COL_PAUSE),
                                       f_at(cb, O_EXIT2 + 5'd3), 1'b0, SRC_ZERO, 1'b0);
            O_EXIT2 + 5'd2: w = f_word(UOP_CALL, '0, f_at(cb, O_PAUSE), 1'b0, SRC_ZERO, 1'b0);
            O_EXIT2 + 5'd3: w = f_word(UOP_EMRET, '0, A_RET, 1'b1, SRC_ZERO, 1'b0);
            // Update: from Pause via Exit2, else via Exit1 with TDI high
            O_UPD:         w = f_word(UOP_BR, f_onehot(b + COL_UPD), A_RET,
                                      1'b0, SRC_ZERO, 1'b0);
            O_UPD + 5'd1:  w = f_word(UOP_BR, f_onehot(b + COL_EXIT1) | f_onehot(b + COL_EXIT2),
                                      f_at(cb, O_UPD + 5'd4), 1'b0, SRC_ZERO, 1'b0);
            O_UPD + 5'd2:  w = f_word(UOP_BR, f_onehot(b + COL_PAUSE),
                                      f_at(cb, O_UPD + 5'd5), 1'b0, SRC_ZERO, 1'b0);
            O_UPD + 5'd3:  w = f_word(UOP_CALL, '0, f_at(cb, O_EXIT1), 1'b0, SRC_ONE, 1'b0);
            O_UPD + 5'd4:  w = f_word(UOP_EMRET, '0, A_RET, 1'b1, SRC_ZERO, 1'b0);
            O_UPD + 5'd5:  w = f_word(UOP_CALL, '0, f_at(cb, O_EXIT2), 1'b0, SRC_ZERO, 1'b0);
            O_UPD + 5'd6:  w = f_word(UOP_EMRET, '0, A_RET, 1'b1, SRC_ZERO, 1'b0);
            default:       w = f_word(UOP_RET, '0, A_RET, 1'b0, SRC_ZERO, 1'b0);
        endcase
        return w;
    endfunction

    function automatic t_uword f_urom(input t_uaddr addr);
        t_uword w;
        w = f_word(UOP_RET, '0, A_RET, 1'b0, SRC_ZERO, 1'b0);
        if (addr >= A_IR && addr < A_IR + COL_LEN) begin
            w = f_col_word(t_uoff'(addr - A_IR), 1'b1);
        end else if (addr >= A_DR && addr < A_DR + COL_LEN) begin
            w = f_col_word(t_uoff'(addr - A_DR), 1'b0);
        end else begin
            case (addr)
                // Test-Logic-Reset: five pulses with TMS high
                A_RESET, A_RESET + 7'd1, A_RESET + 7'd2, A_RESET + 7'd3:
                    w = f_word(UOP_EMIT, '0, A_RET, 1'b1, SRC_ZERO, 1'b0);
                A_RESET + 7'd4:
                    w = f_word(UOP_EMRET, '0, A_RET, 1'b1, SRC_ZERO, 1'b0);
                // Run-Test/Idle: leave a scan column through its Update, a Select state through Test-Logic-Reset
                A_RTI:
                    w = f_word(UOP_BR, f_onehot(ST_SEL_DR), A_RTI + 7'd5,
                               1'b0, SRC_ZERO, 1'b0);
                A_RTI + 7'd1:
                    w = f_word(UOP_BR, f_onehot(ST_SEL_IR), A_RTI + 7'd6,
                               1'b0, SRC_ZERO, 1'b0);
                A_RTI + 7'd2:
                    w = f_word(UOP_BR, f_onehot(ST_CAP_DR) | f_onehot(ST_SHIFT_DR)
                               | f_onehot(ST_EXIT1_DR) | f_onehot(ST_PAUSE_DR)
                               | f_onehot(ST_EXIT2_DR),
                               A_RTI + 7'd8, 1'b0, SRC_ZERO, 1'b0);
                A_RTI + 7'd3:
                    w = f_word(UOP_BR, f_onehot(ST_CAP_IR) | f_onehot(ST_SHIFT_IR)
                               | f_onehot(ST_EXIT1_IR) | f_onehot(ST_PAUSE_IR)
                               | f_onehot(ST_EXIT2_IR),
                               A_RTI + 7'd10, 1'b0, SRC_ZERO, 1'b0);
                A_RTI + 7'd4, A_RTI + 7'd7, A_RTI + 7'd9, A_RTI + 7'd11:
                    w = f_word(UOP_EMRET, '0, A_RET, 1'b0, SRC_ZERO, 1'b0);
                A_RTI + 7'd5, A_RTI + 7'd6:
                    w = f_word(UOP_EMIT, '0, A_RET, 1'b1, SRC_ZERO, 1'b0);
                A_RTI + 7'd8:
                    w = f_word(UOP_CALL, '0, f_at(A_DR, O_UPD), 1'b0, SRC_ZERO, 1'b0);
                A_RTI + 7'd10:
                    w = f_word(UOP_CALL, '0, f_at(A_IR, O_UPD), 1'b0, SRC_ZERO, 1'b0);
                default:
                    w = f_word(UOP_RET, '0, A_RET, 1'b0, SRC_ZERO, 1'b0);
            endcase
        end
        return w;
    endfunction

    // entry point of the routine for a command
    function automatic t_uaddr f_entry(input t_tap opc);
        logic   is_ir;
        t_tap   kind;
        t_uoff  off;
        t_uaddr ent;
        is_ir = (opc >= ST_SEL_IR);
        kind  = opc - (is_ir ? ST_SEL_IR : ST_SEL_DR);
        case (kind)
            COL_CAP:   off = O_CAP;
            COL_SHIFT: off = O_SHIFT;
            COL_EXIT1: off = O_EXIT1;
            COL_PAUSE: off = O_PAUSE;
            COL_EXIT2: off = O_EXIT2;
            COL_UPD:   off = O_UPD;
            default:   off = O_SEL;
        endcase
        if (opc == ST_TLR) begin
            ent = A_RESET;
        end else if (opc == ST_RTI) begin
            ent = A_RTI;
        end else begin
            ent = f_at(is_ir ? A_IR : A_DR, off);
        end
        return ent;
    endfunction

endpackage

// ===== hdl/jtag_tap_state_walker.sv =====
// ----------------------------------------------------------------------------
// jtag_tap_state_walker - JTAG master TAP state walker
// Takes a command naming a target TAP state and gives the run of TCK pulses
// (TMS, TDI, sample flag, last flag) that moves the tracked TAP state there.
//
//   channel   direction  handshake          payload
//   command   in         i_valid / o_stall  i_opcode[3:0], i_data_bit
//   pulse     out        o_valid / i_stall  o_mode_select, o_serial_out,
//                                           o_sample_return, o_last_pulse
//
// One microinstruction per cycle from the routing ROM, unless a pulse step
// waits on a stalled pulse; a return after a pulse is folded into that pulse.
// A command gives up to 9 pulses and nests up to 8 calls; the next command
// is taken once the routine returns at the outer level.
// Synchronous reset clears the sequencer and sets Test-Logic-Reset.
// A stalled pulse holds the sequencer only on its next pulse step.
// ----------------------------------------------------------------------------
module jtag_tap_state_walker
    import jtw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_opcode,
    input  logic       i_data_bit,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_mode_select,
    output logic       o_serial_out,
    output logic       o_sample_return,
    output logic       o_last_pulse
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_seq_state;

    t_seq_state           r_state, n_state;
    t_uaddr               r_pc, n_pc;
    logic                 r_bit, n_bit;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    t_frame               r_stack [STACK_DEPTH];
    t_tap                 r_tap, n_tap;
    logic                 r_out_valid, n_out_valid;
    logic                 r_tms, n_tms;
    logic                 r_tdi, n_tdi;
    logic                 r_smp, n_smp;
    logic                 r_last, n_last;

    t_uword               uword;
    t_frame               top;
    logic [IDX_W-1:0]     top_idx;
    logic                 src_val;
    logic                 out_free;
    logic                 emit;
    logic                 do_ret;
    logic                 push;

    assign uword    = f_urom(r_pc);
    assign top_idx  = IDX_W'(r_depth - DEPTH_W'(1));
    assign top      = r_stack[top_idx];
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        case (uword.src)
            SRC_ONE:   src_val = 1'b1;
            SRC_FRAME: src_val = r_bit;
            default:   src_val = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_bit   = r_bit;
        n_depth = r_depth;
        emit    = 1'b0;
        do_ret  = 1'b0;
        push    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RUN;
                    n_pc    = f_entry(i_opcode);
                    n_bit   = i_data_bit;
                    n_depth = '0;
                end
            end
            S_RUN: begin
                unique case (uword.op)
                    UOP_BR: begin
                        n_pc = uword.mask[r_tap] ? uword.dest : r_pc + t_uaddr'(1);
                    end
                    UOP_CALL: begin
                        push    = 1'b1;
                        n_depth = r_depth + DEPTH_W'(1);
                        n_pc    = uword.dest;
                        n_bit   = src_val;
                    end
                    UOP_EMIT: begin
                        if (out_free) begin
                            emit = 1'b1;
                            n_pc = r_pc + t_uaddr'(1);
                        end
                    end
                    UOP_EMRET: begin
                        if (out_free) begin
                            emit   = 1'b1;
                            do_ret = 1'b1;
                        end
                    end
                    default: begin
                        do_ret = 1'b1;
                    end
                endcase

                // pop a frame, or finish the command at the outer level
                if (do_ret) begin
                    if (r_depth == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pc    = top.ret;
                        n_bit   = top.bit_val;
                        n_depth = r_depth - DEPTH_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = emit || (r_out_valid && i_stall);
        n_tms       = emit ? uword.tms : r_tms;
        n_tdi       = emit ? src_val : r_tdi;
        n_smp       = emit ? uword.smp : r_smp;
        n_last      = emit ? (do_ret && r_depth == '0) : r_last;
        n_tap       = emit ? f_tap_next(r_tap, uword.tms) : r_tap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= A_RESET;
            r_depth     <= '0;
            r_tap       <= ST_TLR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_depth     <= n_depth;
            r_tap       <= n_tap;
            r_out_valid <= n_out_valid;
        end
        r_bit  <= n_bit;
        r_tms  <= n_tms;
        r_tdi  <= n_tdi;
        r_smp  <= n_smp;
        r_last <= n_last;
        if (push) begin
            r_stack[r_depth[IDX_W-1:0]] <= '{ret: r_pc + t_uaddr'(1), bit_val: r_bit};
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_mode_select   = r_tms;
    assign o_serial_out    = r_tdi;
    assign o_sample_return = r_smp;
    assign o_last_pulse    = r_last;

endmodule

// ===== hdl/jtw_checker.sv =====
// ----------------------------------------------------------------------------
// jtw_checker - port-level checks for the JTAG TAP state walker
// Watches both channels and flags sequencing slips over time.
// ----------------------------------------------------------------------------
module jtw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [3:0] i_opcode,
    input logic       i_data_bit,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_mode_select,
    input logic       o_serial_out,
    input logic       o_sample_return,
    input logic       o_last_pulse
);

    // after a command transfer the command side is held in the next cycle
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("command side not held after a command transfer");

    // a pulse that is not the last one means the command is still running
    a_mid_pulse_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_pulse) |-> o_stall)
        else $error("next command taken before the last pulse");

    // a sampled pulse is the closing Shift pulse: TMS low and last
    a_sample_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sample_return) |-> (o_last_pulse && !o_mode_select))
        else $error("sample flag on a pulse that is not the closing Shift pulse");

    // a stalled pulse stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mode_select)
                                  && $stable(o_serial_out) && $stable(o_sample_return)
                                  && $stable(o_last_pulse)))
        else $error("stalled pulse changed");

endmodule

bind jtag_tap_state_walker jtw_checker u_jtw_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for the JTAG TAP state walker
// Drives TAP target commands and checks every TCK pulse against a local
// routing predictor that tracks the TAP state. A directed table covers each
// command and the already-there and detour cases, then random commands run
// under four idling phases on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jtw_pkg::*;

    localparam int   MAX_PULSES   = 10;
    localparam int   N_DIRECTED   = 28;
    localparam int   CMDS_PER_PH  = 100;
    localparam int   DRAIN_CYCLES = 64;
    localparam int   CYCLE_LIMIT  = 500000;
    localparam int   REPORT_MAX   = 10;
    localparam logic PREDICTED    = 1'b0;
    localparam logic TYPED        = 1'b1;

    typedef enum int {
        PH_NONE,
        PH_SENDER,
        PH_RECEIVER,
        PH_BOTH
    } idle_phase_t;

    typedef struct packed {
        logic mode_select;
        logic serial_out;
        logic sample_return;
        logic last_pulse;
    } pulse_t;

    // tms holds pulse k at bit k; typed rows carry TDI 0 and no sample flag
    typedef struct packed {
        t_tap       opc;
        logic       dbit;
        logic       typed;
        logic [3:0] n;
        logic [9:0] tms;
    } cmd_row_t;

    // TAP transition table, one array per TMS level
    localparam t_tap TAP_NEXT_TMS0 [16] = '{
        ST_RTI, ST_RTI, ST_CAP_DR, ST_SHIFT_DR, ST_SHIFT_DR, ST_PAUSE_DR,
        ST_PAUSE_DR, ST_SHIFT_DR, ST_RTI, ST_CAP_IR, ST_SHIFT_IR, ST_SHIFT_IR,
        ST_PAUSE_IR, ST_PAUSE_IR, ST_SHIFT_IR, ST_RTI
    };
    localparam t_tap TAP_NEXT_TMS1 [16] = '{
        ST_TLR, ST_SEL_DR, ST_SEL_IR, ST_EXIT1_DR, ST_EXIT1_DR, ST_UPD_DR,
        ST_EXIT2_DR, ST_UPD_DR, ST_SEL_DR, ST_TLR, ST_EXIT1_IR, ST_EXIT1_IR,
        ST_UPD_IR, ST_EXIT2_IR, ST_UPD_IR, ST_SEL_DR
    };

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       o_stall;
    logic [3:0] i_opcode   = '0;
    logic       i_data_bit = 1'b0;
    logic       o_valid;
    logic       i_stall    = 1'b0;
    logic       o_mode_select;
    logic       o_serial_out;
    logic       o_sample_return;
    logic       o_last_pulse;

    t_tap   tap_track = ST_TLR;
    pulse_t cmd_pulses [$];
    pulse_t pulse_q    [$];
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     mismatches     = 0;
    int     cycle_count    = 0;

    jtag_tap_state_walker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_data_bit      (i_data_bit),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_mode_select   (o_mode_select),
        .o_serial_out    (o_serial_out),
        .o_sample_return (o_sample_return),
        .o_last_pulse    (o_last_pulse)
    );

    always #6 i_clk = ~i_clk;

    function automatic void push_pulse(input logic tms, input logic tdi, input logic smp);
        pulse_t p;
        p.mode_select   = tms;
        p.serial_out    = tdi;
        p.sample_return = smp;
        p.last_pulse    = 1'b0;
        if (cmd_pulses.size() < MAX_PULSES) begin
            cmd_pulses.push_back(p);
        end
        tap_track = tms ? TAP_NEXT_TMS1[tap_track] : TAP_NEXT_TMS0[tap_track];
    endfunction

    // Walk to the target through usual predecessors, with an explicit stack
    // of pending targets in place of nested routines.
    function automatic void route_command(input t_tap opc, input logic dbit);
        t_tap   goal   [16];
        logic   gbit   [16];
        logic   opened [16];
        int     sp;
        int     top;
        t_tap   g;
        t_tap   st;
        t_tap   base;
        t_tap   pre;
        logic   pre_bit;
        logic   need_pre;
        logic   skip;
        logic   is_ir;
        pulse_t p;
        cmd_pulses.delete();
        goal[0]   = opc;
        gbit[0]   = dbit;
        opened[0] = 1'b0;
        sp = 1;
        while (sp > 0) begin
            top      = sp - 1;
            g        = goal[top];
            st       = tap_track;
            is_ir    = (g >= ST_SEL_IR);
            base     = is_ir ? ST_SEL_IR : ST_SEL_DR;
            need_pre = 1'b0;
            pre      = g;
            pre_bit  = 1'b0;
            skip     = 1'b0;
            if (!opened[top]) begin
                opened[top] = 1'b1;
                if (g == ST_TLR) begin
                    repeat (5) push_pulse(1'b1, 1'b0, 1'b0);
                    skip = 1'b1;
                end else if (g == ST_RTI) begin
                    // leave Select-DR by way of Select-IR and Test-Logic-Reset
                    if (st == ST_SEL_DR) begin
                        push_pulse(1'b1, 1'b0, 1'b0);
                        push_pulse(1'b1, 1'b0, 1'b0);
                    end else if (st == ST_SEL_IR) begin
                        push_pulse(1'b1, 1'b0, 1'b0);
                    end else if (st >= ST_CAP_DR && st <= ST_EXIT2_DR) begin
                        need_pre = 1'b1;
                        pre      = ST_UPD_DR;
                    end else if (st >= ST_CAP_IR && st <= ST_EXIT2_IR) begin
                        need_pre = 1'b1;
                        pre      = ST_UPD_IR;
                    end
                end else begin
                    case (t_tap'(g - base))
                        COL_CAP: begin
                            if (st == g) begin
                                skip = 1'b1;
                            end else if (st != base) begin
                                need_pre = 1'b1;
                                pre      = base;
                            end
                        end
                        COL_SHIFT: begin
                            if (st != base + COL_SHIFT && st != base + COL_CAP &&
                                st != base + COL_EXIT2) begin
                                need_pre = 1'b1;
                                pre      = base + COL_CAP;
                            end
                        end
                        COL_EXIT1: begin
                            if (st == g) begin
                                skip = 1'b1;
                            end else if (st != base + COL_CAP && st != base + COL_SHIFT) begin
                                need_pre = 1'b1;
                                pre      = base + COL_CAP;
                            end
                        end
                        COL_PAUSE: begin
                            // the Exit1 on the way carries TDI high only in the IR column
                            if (st != base + COL_EXIT1 && st != base + COL_PAUSE) begin
                                need_pre = 1'b1;
                                pre      = base + COL_EXIT1;
                                pre_bit  = is_ir;
                            end
                        end
                        COL_EXIT2: begin
                            if (st == g) begin
                                skip = 1'b1;
                            end else if (st != base + COL_PAUSE) begin
                                need_pre = 1'b1;
                                pre      = base + COL_PAUSE;
                            end
                        end
                        COL_UPD: begin
                            if (st == g) begin
                                skip = 1'b1;
                            end else if (st == base + COL_PAUSE) begin
                                need_pre = 1'b1;
                                pre      = base + COL_EXIT2;
                            end else if (st != base + COL_EXIT1 && st != base + COL_EXIT2) begin
                                need_pre = 1'b1;
                                pre      = base + COL_EXIT1;
                                pre_bit  = 1'b1;
                            end
                        end
                        default: begin
                            if (st == g) begin
                                skip = 1'b1;
                            end else if (is_ir || st != ST_RTI) begin
                                need_pre = 1'b1;
                                pre      = is_ir ? ST_SEL_DR : ST_RTI;
                            end
                        end
                    endcase
                end
            end
            if (need_pre) begin
                goal[sp]   = pre;
                gbit[sp]   = pre_bit;
                opened[sp] = 1'b0;
                sp++;
            end else begin
                // closing pulse of this target, then drop the frame
                if (!skip) begin
                    if (g == ST_RTI) begin
                        push_pulse(1'b0, 1'b0, 1'b0);
                    end else begin
                        case (t_tap'(g - base))
                            COL_CAP, COL_PAUSE: push_pulse(1'b0, 1'b0, 1'b0);
                            COL_SHIFT:          push_pulse(1'b0, gbit[top], 1'b1);
                            COL_EXIT1:          push_pulse(1'b1, gbit[top], 1'b0);
                            default:            push_pulse(1'b1, 1'b0, 1'b0);
                        endcase
                    end
                end
                sp--;
            end
        end
        if (cmd_pulses.size() > 0) begin
            p = cmd_pulses.pop_back();
            p.last_pulse = 1'b1;
            cmd_pulses.push_back(p);
        end
    endfunction

    task automatic set_idling(input idle_phase_t ph);
        send_idle_pct  = (ph == PH_SENDER)   ? 66 : (ph == PH_BOTH) ? 18 : 0;
        recv_stall_pct = (ph == PH_RECEIVER) ? 66 : (ph == PH_BOTH) ? 18 : 0;
    endtask

    task automatic send_command(input cmd_row_t row);
        pulse_t p;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= row.opc;
        i_data_bit <= row.dbit;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // transfer taken at this edge: advance the tracked state
        route_command(row.opc, row.dbit);
        if (row.typed) begin
            cmd_pulses.delete();
            for (int k = 0; k < row.n; k++) begin
                p.mode_select   = row.tms[k];
                p.serial_out    = 1'b0;
                p.sample_return = 1'b0;
                p.last_pulse    = (k == row.n - 1);
                cmd_pulses.push_back(p);
            end
        end
        foreach (cmd_pulses[k]) pulse_q.push_back(cmd_pulses[k]);
    endtask

    always @(posedge i_clk) begin : pulse_check
        pulse_t got;
        pulse_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_mode_select, o_serial_out, o_sample_return, o_last_pulse};
            if (pulse_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected pulse: tms %b tdi %b smp %b last %b",
                             got.mode_select, got.serial_out, got.sample_return,
                             got.last_pulse);
                end
            end else begin
                want = pulse_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("pulse mismatch: expected tms %b tdi %b smp %b last %b, got tms %b tdi %b smp %b last %b",
                                 want.mode_select, want.serial_out, want.sample_return,
                                 want.last_pulse, got.mode_select, got.serial_out,
                                 got.sample_return, got.last_pulse);
                    end
                end
            end
        end
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        cmd_row_t rows [N_DIRECTED];
        cmd_row_t row;
        t_tap     opc;
        t_tap     last_opc;
        int       r;
        rows[0]  = {ST_TLR,      1'b0, TYPED,     4'd5, 10'b0000011111};
        rows[1]  = {ST_RTI,      1'b0, TYPED,     4'd1, 10'b0000000000};
        rows[2]  = {ST_RTI,      1'b1, TYPED,     4'd1, 10'b0000000000};
        rows[3]  = {ST_SEL_DR,   1'b0, TYPED,     4'd1, 10'b0000000001};
        rows[4]  = {ST_SEL_DR,   1'b0, TYPED,     4'd0, 10'b0000000000};
        rows[5]  = {ST_RTI,      1'b0, TYPED,     4'd3, 10'b0000000011};
        rows[6]  = {ST_CAP_DR,   1'b0, PREDICTED, 4'd0, 10'b0};
        rows[7]  = {ST_SHIFT_DR, 1'b1, PREDICTED, 4'd0, 10'b0};
        rows[8]  = {ST_SHIFT_DR, 1'b0, PREDICTED, 4'd0, 10'b0};
        rows[9]  = {ST_EXIT1_DR, 1'b1, PREDICTED, 4'd0, 10'b0};
        rows[10] = {ST_EXIT1_DR, 1'b0, TYPED,     4'd0, 10'b0000000000};
        rows[11] = {ST_PAUSE_DR, 1'b0, PREDICTED, 4'd0, 10'b0};
        rows[12] = {ST_PAUSE_DR, 1'b1, PREDICTED, 4'd0, 10'b0};
        rows[13] = {ST_EXIT2_DR, 1'b0, PREDICTED, 4'd0, 10'b0};
        rows[14] = {ST_EXIT2_DR, 1'b0, TYPED,     4'd0, 10'b0000000000};
        rows[15] = {ST_SHIFT_DR, 1'b1, PREDICTED, 4'd0, 10'b0};
        rows[16] = {ST_UPD_DR,   1'b0, PREDICTED, 4'd0, 10'b0};
        rows[17] = {ST_UPD_DR,   1'b0, TYPED,     4'd0, 10'b0000000000};
        rows[18] = {ST_CAP_IR,   1'b0, PREDICTED, 4'd0, 10'b0};
        rows[19] = {ST_PAUSE_IR, 1'b0, PREDICTED, 4'd0, 10'b0};
        rows[20] = {ST_UPD_IR,   1'b1, PREDICTED, 4'd0, 10'b0};
        rows[21] = {ST_SEL_IR,   1'b0, PREDICTED, 4'd0, 10'b0};
        rows[22] = {ST_SEL_IR,   1'b0, TYPED,     4'd0, 10'b0000000000};
        rows[23] = {ST_RTI,      1'b0, TYPED,     4'd2, 10'b0000000001};
        rows[24] = {ST_SHIFT_IR, 1'b1, PREDICTED, 4'd0, 10'b0};
        rows[25] = {ST_EXIT1_IR, 1'b0, PREDICTED, 4'd0, 10'b0};
        rows[26] = {ST_EXIT2_IR, 1'b0, PREDICTED, 4'd0, 10'b0};
        rows[27] = {ST_TLR,      1'b1, TYPED,     4'd5, 10'b0000011111};

        set_idling(PH_NONE);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_command(rows[k]);
        end

        last_opc = ST_TLR;
        for (int ph = PH_NONE; ph <= PH_BOTH; ph++) begin
            set_idling(idle_phase_t'(ph));
            for (int k = 0; k < CMDS_PER_PH; k++) begin
                // mostly fresh targets, some repeats for the already-there cases
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    opc = ST_TLR;
                end else if (r < 23) begin
                    opc = last_opc;
                end else begin
                    opc = t_tap'($urandom_range(1, 15));
                end
                row = {opc, 1'($urandom_range(0, 1)), PREDICTED, 4'd0, 10'b0};
                send_command(row);
                last_opc = opc;
            end
        end
        i_valid <= 1'b0;

        while (pulse_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pulse_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/jtw_pkg.sv
hdl/jtag_tap_state_walker.sv
hdl/jtw_checker.sv
bench/tb.sv
